// ===== rtl/kpsdt_pkg.sv =====
package kpsdt_pkg;

  // Keypad geometry
  localparam int COLUMNS     = 3;
  localparam int ROWS        = 5;
  localparam int MATRIX_KEYS = COLUMNS * ROWS;
  localparam int CODE_W      = 5;
  localparam int CNT_W       = 8;

  // Key codes
  localparam logic [CODE_W-1:0] CODE_NONE   = '0;
  localparam logic [CODE_W-1:0] CODE_SINGLE = CODE_W'(MATRIX_KEYS + 1);

  // Tick dividers (1 kHz base)
  localparam int TICK_W    = 16;
  localparam int DIV_100HZ = 10;
  localparam int DIV_10HZ  = 100;
  localparam int DIV_1HZ   = 1000;
  localparam int R10_W     = $clog2(DIV_100HZ);
  localparam int R100_W    = $clog2(DIV_10HZ);
  localparam int R1000_W   = $clog2(DIV_1HZ);

  // Configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic REG_PRESS_THRESHOLD = 1'b0;
  localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd20;

  // Divider and backlight results of one tick
  typedef struct packed {
    logic pulse_100hz;
    logic pulse_10hz;
    logic pulse_1hz;
    logic backlight_on;
  } tick_res_t;

  // One result item
  typedef struct packed {
    tick_res_t         tick;
    logic [CODE_W-1:0] key_code;
  } result_t;

endpackage

// ===== rtl/kpsdt_key_lane.sv =====
module kpsdt_key_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [kpsdt_pkg::CNT_W-1:0] thr,
  input  logic                       pressed,
  output logic                       released
);
  import kpsdt_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] cnt_inc;

  // Saturating count, clamped to the threshold while held
  always_comb begin
    cnt_inc  = (cnt_r == '1) ? cnt_r : cnt_r + CNT_W'(1);
    released = 1'b0;
    cnt_nxt  = cnt_r;
    if (pressed) begin
      cnt_nxt = (cnt_inc >= thr) ? thr : cnt_inc;
    end else if (cnt_r >= thr) begin
      released = 1'b1;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (en) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/kpsdt_code_merge.sv =====
module kpsdt_code_merge (
  input  logic [kpsdt_pkg::MATRIX_KEYS-1:0] matrix_rel,
  input  logic                             single_rel,
  output logic [kpsdt_pkg::CODE_W-1:0]      key_code
);
  import kpsdt_pkg::*;

  // Last released key in scan order wins; the separate key is scanned first
  always_comb begin
    key_code = single_rel ? CODE_SINGLE : CODE_NONE;
    for (int k = 0; k < MATRIX_KEYS; k++) begin
      if (matrix_rel[k]) begin
        key_code = CODE_W'(k + 1);
      end
    end
  end

endmodule

// ===== rtl/kpsdt_tick_div.sv =====
module kpsdt_tick_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    timeout_load,
  input  logic [7:0]              timeout_value,
  output kpsdt_pkg::tick_res_t    res
);
  import kpsdt_pkg::*;

  logic [TICK_W-1:0]  tick_r,  tick_nxt;
  logic [R10_W-1:0]   r10_r,   r10_nxt;
  logic [R100_W-1:0]  r100_r,  r100_nxt;
  logic [R1000_W-1:0] r1000_r, r1000_nxt;
  logic [7:0]         timeout_r, timeout_nxt;
  logic               level_r,   level_nxt;
  logic               wrap;
  logic [7:0]         timeout_cur;

  // Residues track the count modulo each divisor; all restart when the count wraps
  always_comb begin
    tick_nxt  = tick_r + TICK_W'(1);
    wrap      = (tick_r == '1);
    r10_nxt   = (wrap || r10_r == R10_W'(DIV_100HZ - 1)) ? '0 : r10_r + R10_W'(1);
    r100_nxt  = (wrap || r100_r == R100_W'(DIV_10HZ - 1)) ? '0 : r100_r + R100_W'(1);
    r1000_nxt = (wrap || r1000_r == R1000_W'(DIV_1HZ - 1)) ? '0
                : r1000_r + R1000_W'(1);
  end

  // Backlight timeout, reloaded ahead of the tick
  always_comb begin
    timeout_cur = timeout_load ? timeout_value : timeout_r;
    timeout_nxt = timeout_cur;
    level_nxt   = level_r;
    if (r1000_nxt == '0) begin
      if (timeout_cur != '0) begin
        timeout_nxt = timeout_cur - 8'd1;
        level_nxt   = 1'b1;
      end else begin
        level_nxt   = 1'b0;
      end
    end
  end

  always_comb begin
    res.pulse_100hz  = (r10_nxt == '0);
    res.pulse_10hz   = (r100_nxt == '0);
    res.pulse_1hz    = (r1000_nxt == '0);
    res.backlight_on = level_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      r10_r     <= '0;
      r100_r    <= '0;
      r1000_r   <= '0;
      timeout_r <= '0;
      level_r   <= 1'b0;
    end else if (en) begin
      tick_r    <= tick_nxt;
      r10_r     <= r10_nxt;
      r100_r    <= r100_nxt;
      r1000_r   <= r1000_nxt;
      timeout_r <= timeout_nxt;
      level_r   <= level_nxt;
    end
  end

endmodule

// ===== rtl/keypad_scan_debounce_tick.sv =====
// Keypad debouncer with 1 kHz tick dividers and backlight timeout.
// Input channel (in_*): one transfer per 1 ms tick carrying the row readings
// of the three columns, the separate key level and an optional timeout reload.
// Output channel (out_*): exactly one result transfer per input transfer, in
// order: 100 Hz / 10 Hz / 1 Hz pulses, released key code and backlight level.
// All fifteen matrix key counters, one lane each, and the separate key counter
// update in the same cycle, and a priority merge picks the reported code.
// Results are registered in the output register, via the skid register while the output stalls.
// One item per cycle is taken while in_stall is low; the lane update sets this.
// A skid register behind the output register holds one extra result, so an
// item is still taken in the cycle the output first stalls; in_stall rises
// only while that skid register is full.
// Reset (rst_n low, synchronous) clears the tick count, all key counters, the
// backlight timeout and level, and sets press_threshold to 20.
// press_threshold is written over the APB port at byte address 0, by the user only while idle (not enforced).
module keypad_scan_debounce_tick (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [4:0]                          in_column0_rows,
  input  logic [4:0]                          in_column1_rows,
  input  logic [4:0]                          in_column2_rows,
  input  logic                                in_single_key_level,
  input  logic                                in_timeout_load,
  input  logic [7:0]                          in_timeout_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_pulse_100hz,
  output logic                                out_pulse_10hz,
  output logic                                out_pulse_1hz,
  output logic [4:0]                          out_key_code,
  output logic                                out_backlight_on,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [kpsdt_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [kpsdt_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [kpsdt_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready
);
  import kpsdt_pkg::*;

  logic [CNT_W-1:0]       thr_r;
  logic                   in_fire;
  logic                   out_fire;
  logic [ROWS-1:0]        col_rows [COLUMNS];
  logic [MATRIX_KEYS-1:0] matrix_rel;
  logic [CNT_W-1:0]       single_cnt_r, single_cnt_nxt;
  logic                   single_rel;
  logic [CODE_W-1:0]      key_code;
  tick_res_t              tick_res;
  result_t                new_res;
  result_t                out_r, out_nxt;
  result_t                skid_r, skid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   skid_valid_r, skid_valid_nxt;

  // APB register access
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_W-1] == REG_PRESS_THRESHOLD) begin
      prdata = CFG_DATA_W'(thr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[CFG_ADDR_W-1] == REG_PRESS_THRESHOLD) begin
      thr_r <= pwdata[CNT_W-1:0];
    end
  end

  // Handshake
  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;

  // Matrix key lanes
  assign col_rows[0] = in_column0_rows;
  assign col_rows[1] = in_column1_rows;
  assign col_rows[2] = in_column2_rows;

  for (genvar c = 0; c < COLUMNS; c++) begin : g_col
    for (genvar r = 0; r < ROWS; r++) begin : g_row
      kpsdt_key_lane u_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (in_fire),
        .thr      (thr_r),
        .pressed  (col_rows[c] == (ROWS'(1) << r)),
        .released (matrix_rel[c*ROWS + r])
      );
    end
  end

  // Separate key: active low, clears on every release
  always_comb begin
    single_rel     = 1'b0;
    single_cnt_nxt = '0;
    if (!in_single_key_level) begin
      single_cnt_nxt = (single_cnt_r == '1) ? single_cnt_r : single_cnt_r + CNT_W'(1);
    end else begin
      single_rel = (single_cnt_r >= thr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_cnt_r <= '0;
    end else if (in_fire) begin
      single_cnt_r <= single_cnt_nxt;
    end
  end

  kpsdt_code_merge u_merge (
    .matrix_rel (matrix_rel),
    .single_rel (single_rel),
    .key_code   (key_code)
  );

  kpsdt_tick_div u_tick (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (in_fire),
    .timeout_load  (in_timeout_load),
    .timeout_value (in_timeout_value),
    .res           (tick_res)
  );

  assign new_res.tick     = tick_res;
  assign new_res.key_code = key_code;

  // Output register with skid stage
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = new_res;
        out_valid_nxt = in_fire;
      end
    end else if (in_fire) begin
      skid_nxt       = new_res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pulse_100hz  = out_r.tick.pulse_100hz;
  assign out_pulse_10hz   = out_r.tick.pulse_10hz;
  assign out_pulse_1hz    = out_r.tick.pulse_1hz;
  assign out_key_code     = out_r.key_code;
  assign out_backlight_on = out_r.tick.backlight_on;

  // Skid stage only holds a result behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full with output register empty");

  // A stalled output with a full skid stage must not take new items
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_stall) |=> skid_valid_r && $stable(skid_r))
    else $error("skid result lost while output stalled");

  // Divider pulses nest
  a_pulse_nest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pulse_1hz) |-> (out_pulse_10hz && out_pulse_100hz))
    else $error("1 Hz pulse without 10 Hz and 100 Hz pulses");

  // Key code within range
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_key_code <= CODE_SINGLE))
    else $error("key code out of range");

endmodule
